>>> rtl/q24_pkg.sv
// package for the q24.8 fixed-point alu: command codes and item field widths
`default_nettype none
package q24_pkg;

    localparam int unsigned CMD_W  = 4;
    localparam int unsigned DATA_W = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD     = 4'd0,
        CMD_SUB     = 4'd1,
        CMD_MUL     = 4'd2,
        CMD_DIV     = 4'd3,
        CMD_CMP     = 4'd4,
        CMD_MIN     = 4'd5,
        CMD_MAX     = 4'd6,
        CMD_INC     = 4'd7,
        CMD_DEC     = 4'd8,
        CMD_TOINT   = 4'd9,
        CMD_FROMINT = 4'd10
    } t_cmd;

    typedef struct packed {
        logic is_equal;
        logic is_less;
        logic is_greater;
        logic div_by_zero;
    } t_flags;

endpackage
`default_nettype wire

>>> rtl/q24_8_fixed_point_alu.sv
// top level of the q24.8 fixed-point alu: deep pipeline with a bit-per-stage divider
`default_nettype none
//  channel | dir | handshake                | payload
//  s_axis  | in  | i_s_axis_tvalid/tready   | command, operand_a, operand_b
//  m_axis  | out | o_m_axis_tvalid/tready   | result_value, eq, lt, gt, div_by_zero
//
// every item passes from acceptance to output through one input stage, one stage for
// the multiplier and operand setup, one restoring divider stage per quotient bit
// (32 + FRAC_BITS), and the output stage
// one item per cycle sustained while the output is not stalled; all commands flow through the same stages in order
// the whole pipeline halts while the output item waits; empty slots ahead are kept
// reset clears only the valid bits
module q24_8_fixed_point_alu
    import q24_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // [3:0] command, [35:4] operand_a, [67:36] operand_b, [71:68] zero
    input  wire logic [71:0] i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [31:0] result_value, [32] is_equal, [33] is_less, [34] is_greater,
    // [35] div_by_zero, [39:36] zero
    output logic [39:0]      o_m_axis_tdata
);

    // dividend magnitude width, and number of divider stages
    localparam int unsigned DW = DATA_W + FRAC_BITS;

    // pipeline moves when the output slot is empty or being taken
    logic w_en;
    assign w_en            = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    // input stage
    logic                     r_in_vld;
    logic [CMD_W-1:0]         r_in_cmd;
    logic signed [DATA_W-1:0] r_in_a;
    logic signed [DATA_W-1:0] r_in_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_en) begin
            r_in_vld <= i_s_axis_tvalid;
        end
        if (w_en) begin
            r_in_cmd <= i_s_axis_tdata[3:0];
            r_in_a   <= i_s_axis_tdata[35:4];
            r_in_b   <= i_s_axis_tdata[67:36];
        end
    end

    // setup stage: simple ops, product, divider operands
    logic [DATA_W-1:0]          n_res;
    t_flags                     n_flg;
    logic signed [2*DATA_W-1:0] w_prod;
    logic [DATA_W-1:0]          w_abs_a;
    logic [DATA_W-1:0]          w_abs_b;
    logic                       w_lt;

    assign w_prod  = r_in_a * r_in_b;
    assign w_abs_a = r_in_a[DATA_W-1] ? (~r_in_a + 1'b1) : r_in_a;
    assign w_abs_b = r_in_b[DATA_W-1] ? (~r_in_b + 1'b1) : r_in_b;
    assign w_lt    = r_in_a < r_in_b;

    always_comb begin
        n_res = '0;
        n_flg = '0;
        case (r_in_cmd)
            CMD_ADD:     n_res = r_in_a + r_in_b;
            CMD_SUB:     n_res = r_in_a - r_in_b;
            CMD_CMP: begin
                n_flg.is_equal   = r_in_a == r_in_b;
                n_flg.is_less    = w_lt;
                n_flg.is_greater = !w_lt && (r_in_a != r_in_b);
            end
            CMD_MIN:     n_res = w_lt ? r_in_a : r_in_b;
            CMD_MAX:     n_res = (!w_lt && (r_in_a != r_in_b)) ? r_in_a : r_in_b;
            CMD_INC:     n_res = r_in_a + 1'b1;
            CMD_DEC:     n_res = r_in_a - 1'b1;
            CMD_TOINT:   n_res = r_in_a >>> FRAC_BITS;
            CMD_FROMINT: n_res = r_in_a << FRAC_BITS;
            CMD_DIV:     n_flg.div_by_zero = r_in_b == '0;
            default:     n_res = '0;
        endcase
    end

    // stage arrays: index 0 is the setup stage, 1..DW are divider steps
    logic                     r_vld  [0:DW];
    logic [CMD_W-1:0]         r_cmd  [0:DW];
    logic [DATA_W-1:0]        r_res  [0:DW];
    t_flags                   r_flg  [0:DW];
    logic                     r_neg  [0:DW];
    logic [DATA_W-1:0]        r_dvs  [0:DW];
    logic [DATA_W-1:0]        r_rem  [0:DW];
    logic [DW-1:0]            r_nq   [0:DW];
    logic [2*DATA_W-1:0]      r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= r_in_vld;
        end
        if (w_en) begin
            r_cmd[0]  <= r_in_cmd;
            r_res[0]  <= n_res;
            r_flg[0]  <= n_flg;
            r_prod    <= w_prod;
            r_neg[0]  <= r_in_a[DATA_W-1] ^ r_in_b[DATA_W-1];
            r_dvs[0]  <= w_abs_b;
            r_rem[0]  <= '0;
            r_nq[0]   <= {w_abs_a, {FRAC_BITS{1'b0}}};
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar k = 1; k <= DW; k++) begin : g_div
        logic [DATA_W:0]   w_try;
        logic [DATA_W:0]   w_dif;
        logic              w_ge;
        logic [DATA_W-1:0] w_res;

        assign w_try = {r_rem[k-1], r_nq[k-1][DW-1]};
        assign w_dif = w_try - {1'b0, r_dvs[k-1]};
        assign w_ge  = w_try >= {1'b0, r_dvs[k-1]};

        // multiply result drops in at the first divider step
        if (k == 1) begin : g_mul
            assign w_res = (r_cmd[0] == CMD_MUL) ?
                           r_prod[FRAC_BITS +: DATA_W] : r_res[0];
        end else begin : g_pass
            assign w_res = r_res[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (w_en) begin
                r_vld[k] <= r_vld[k-1];
            end
            if (w_en) begin
                r_cmd[k] <= r_cmd[k-1];
                r_res[k] <= w_res;
                r_flg[k] <= r_flg[k-1];
                r_neg[k] <= r_neg[k-1];
                r_dvs[k] <= r_dvs[k-1];
                r_rem[k] <= w_ge ? w_dif[DATA_W-1:0] : w_try[DATA_W-1:0];
                r_nq[k]  <= {r_nq[k-1][DW-2:0], w_ge};
            end
        end
    end

    // output stage
    logic              r_out_vld;
    logic [DATA_W-1:0] r_out_res;
    t_flags            r_out_flg;
    logic [DATA_W-1:0] w_quot;
    logic [DATA_W-1:0] n_out_res;

    assign w_quot = r_neg[DW] ? (~r_nq[DW][DATA_W-1:0] + 1'b1) : r_nq[DW][DATA_W-1:0];

    always_comb begin
        n_out_res = r_res[DW];
        if (r_cmd[DW] == CMD_DIV) begin
            n_out_res = r_flg[DW].div_by_zero ? '0 : w_quot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_vld[DW];
        end
        if (w_en) begin
            r_out_res <= n_out_res;
            r_out_flg <= r_flg[DW];
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {4'b0000, r_out_flg.div_by_zero, r_out_flg.is_greater,
                              r_out_flg.is_less, r_out_flg.is_equal, r_out_res};

    // at most one compare flag per item
    a_flags_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> $onehot0({r_out_flg.is_equal, r_out_flg.is_less,
                                r_out_flg.is_greater}))
        else $error("compare flags not exclusive");

    // a zero divisor always yields a zero result
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_flg.div_by_zero) |-> (r_out_res == '0))
        else $error("division by zero gave nonzero result");

    // divide flag only follows a divide command
    a_dz_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_vld[DW] && r_flg[DW].div_by_zero) |-> (r_cmd[DW] == CMD_DIV))
        else $error("div_by_zero on non-divide item");

    // a held output item stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_m_axis_tready) |=> (r_out_vld && $stable(r_out_res)))
        else $error("output changed under stall");

endmodule
`default_nettype wire
